// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed outside reset");

// Check a property on every clock edge, reset included.
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("reset assertion failed");

`endif

// ===== design/tnlp_pkg.sv =====
// Types, constants and tables of the tracking notch and low-pass filter.
package tnlp_pkg;

  localparam int CHANNELS     = 9;
  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CORDIC_STEPS = 30;
  localparam int IT_W         = $clog2(CORDIC_STEPS);
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;
  localparam logic signed [31:0] G_MAX        = 32'sh7fffffff;
  localparam logic signed [31:0] G_MIN        = 32'sh80000000;
  localparam logic signed [39:0] S_MAX32      = 40'sd2147483647;
  localparam logic signed [39:0] S_MIN32      = -40'sd2147483648;
  localparam logic signed [39:0] S_MAX33      = 40'sd4294967295;
  localparam logic signed [39:0] S_MIN33      = -40'sd4294967296;

  // Configuration register reset values
  localparam logic [31:0]        RST_PHASE_SLOPE  = 32'd22691;
  localparam logic [31:0]        RST_PHASE_OFFSET = 32'd183085007;
  localparam logic [29:0]        RST_POLE_RADIUS  = 30'd961933088;
  localparam logic signed [31:0] RST_LOWPASS_B0   = 32'sd3888757;
  localparam logic signed [31:0] RST_LOWPASS_A1   = -32'sd1957103853;
  localparam logic signed [31:0] RST_LOWPASS_A2   = 32'sd898917326;

  typedef enum logic [2:0] {
    CFG_PHASE_SLOPE  = 3'd0,
    CFG_PHASE_OFFSET = 3'd1,
    CFG_POLE_RADIUS  = 3'd2,
    CFG_LOWPASS_B0   = 3'd3,
    CFG_LOWPASS_A1   = 3'd4,
    CFG_LOWPASS_A2   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0]        phase_slope;
    logic [31:0]        phase_offset;
    logic [29:0]        pole_radius;
    logic signed [31:0] lowpass_b0;
    logic signed [31:0] lowpass_a1;
    logic signed [31:0] lowpass_a2;
  } cfg_t;

  typedef struct packed {
    logic [CHANNELS-1:0][31:0] sample;
    logic [31:0]               phase;
    logic                      on_ground;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_GROUND, BK_CORDIC, BK_CFIN, BK_RC, BK_RR, BK_RRA,
    BK_DIVPRE, BK_DIVCHK, BK_DIV, BK_GAIN, BK_MUL, BK_ACC, BK_DONE
  } back_state_t;

  typedef enum logic [3:0] {
    OP_NOTCH_X1, OP_NOTCH_GAIN, OP_NOTCH_Y1, OP_NOTCH_Y2,
    OP_LP_Y, OP_LP_L1, OP_LP_L2, OP_LP_Z1, OP_LP_Z2
  } op_t;

  // CORDIC angle of step i, in 2^-32 turns
  function automatic logic [29:0] atan_turns(input logic [IT_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/tnlp_front.sv =====
// Front end: accepts input beats, works out the notch phase, feeds the queue.
module tnlp_front import tnlp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CHANNELS-1:0][31:0] in_sample,
  input  logic [15:0]               in_thrust,
  input  logic                      in_on_ground,
  input  cfg_t                      cfg,
  input  q_status_t                 qst,
  output logic                      push,
  output item_t                     push_item
);

  logic        fr_valid_r, fr_valid_nxt;
  item_t       fr_item_r;
  logic        accept;
  logic [47:0] slope_prod;
  logic [31:0] phase;

  assign push      = fr_valid_r && !qst.full;
  assign in_ready  = !fr_valid_r || !qst.full;
  assign accept    = in_valid && in_ready;
  assign push_item = fr_item_r;

  // Phase wraps modulo one turn
  assign slope_prod = 48'(cfg.phase_slope) * 48'(in_thrust);
  assign phase      = slope_prod[31:0] + cfg.phase_offset;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r.sample    <= in_sample;
      fr_item_r.phase     <= phase;
      fr_item_r.on_ground <= in_on_ground;
    end
  end

endmodule

// ===== design/tnlp_queue.sv =====
// Short item queue between front end and back end.
module tnlp_queue import tnlp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t qst
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign qst.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qst.empty = (cnt_r == '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/tnlp_back.sv =====
// Back end: cosine, notch gain, per-channel notch and low-pass, result register.
module tnlp_back import tnlp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  q_status_t                 qst,
  input  item_t                     q_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CHANNELS-1:0][31:0] out_filtered,
  output logic                      out_saturated
);

  back_state_t state_r, state_nxt;
  op_t         op_r;
  item_t       cur_r;

  logic                     flip_r, flag_r;
  logic signed [33:0]       cx_r, cy_r, cz_r;
  logic [IT_W-1:0]          it_r;
  logic signed [31:0]       c_r, rc_r, rr_r, g_r;
  logic signed [67:0]       prod_r;
  logic                     neg_r;
  logic [32:0]              m_r, den_r;
  logic [33:0]              rem_r;
  logic [31:0]              q_r;
  logic [4:0]               div_it_r;
  logic [CH_W-1:0]          ch_r;
  logic signed [32:0]       t_r;
  logic signed [31:0]       y_r;
  logic signed [39:0]       acc_r;

  logic signed [31:0] hx1_r [CHANNELS];
  logic signed [31:0] hx2_r [CHANNELS];
  logic signed [31:0] hy1_r [CHANNELS];
  logic signed [31:0] hy2_r [CHANNELS];
  logic signed [31:0] hl1_r [CHANNELS];
  logic signed [31:0] hl2_r [CHANNELS];
  logic signed [31:0] hz1_r [CHANNELS];
  logic signed [31:0] hz2_r [CHANNELS];

  logic [CHANNELS-1:0][31:0] res_r;
  logic [CHANNELS-1:0][31:0] out_data_r;
  logic                      out_valid_r, out_sat_r;

  logic               load_out;
  logic signed [33:0] mul_a, mul_b;
  logic signed [37:0] term;
  logic signed [39:0] term40, sum_t, sum_sub;
  logic signed [31:0] x_cur, x1, x2, y1, y2, l1, l2, z1, z2, sat_sub;
  logic signed [32:0] sat_t;
  logic               ovf_t, ovf_sub;
  logic signed [33:0] xs, ys, x_clamped, x_neg;
  logic [33:0]        at34;
  logic [31:0]        a_fold;
  logic               flip_in;
  logic signed [34:0] num_s, den_s, num_abs;
  logic               div_bit, div_ge;
  logic [33:0]        div_rs;
  logic [32:0]        q_neg;

  assign out_valid     = out_valid_r;
  assign out_filtered  = out_data_r;
  assign out_saturated = out_sat_r;

  // Operands of the current channel
  assign x_cur = cur_r.sample[ch_r];
  assign x1 = hx1_r[ch_r];
  assign x2 = hx2_r[ch_r];
  assign y1 = hy1_r[ch_r];
  assign y2 = hy2_r[ch_r];
  assign l1 = hl1_r[ch_r];
  assign l2 = hl2_r[ch_r];
  assign z1 = hz1_r[ch_r];
  assign z2 = hz2_r[ch_r];

  // Product floored by 2^30
  assign term   = prod_r[67:30];
  assign term40 = {{2{term[37]}}, term};

  // Notch input sum, clamped to 33 bits
  assign sum_t = {{8{x_cur[31]}}, x_cur} + {{8{x2[31]}}, x2} - term40;
  assign ovf_t = (sum_t > S_MAX33) || (sum_t < S_MIN33);
  assign sat_t = (sum_t > S_MAX33) ? S_MAX33[32:0] :
                 (sum_t < S_MIN33) ? S_MIN33[32:0] : sum_t[32:0];

  // Last term of a notch or low-pass sum, clamped to 32 bits
  assign sum_sub = acc_r - term40;
  assign ovf_sub = (sum_sub > S_MAX32) || (sum_sub < S_MIN32);
  assign sat_sub = (sum_sub > S_MAX32) ? G_MAX :
                   (sum_sub < S_MIN32) ? G_MIN : sum_sub[31:0];

  // CORDIC step operands and phase fold
  assign xs      = cx_r >>> it_r;
  assign ys      = cy_r >>> it_r;
  assign at34    = {4'b0, atan_turns(it_r)};
  assign flip_in = q_item.phase[31] ^ q_item.phase[30];
  assign a_fold  = flip_in ? (q_item.phase + 32'h8000_0000) : q_item.phase;
  assign x_clamped = (cx_r > Q30_ONE) ? Q30_ONE : (cx_r < -Q30_ONE) ? -Q30_ONE : cx_r;
  assign x_neg     = -x_clamped;

  // Gain numerator and denominator
  assign num_s   = 35'sd1073741824 - {{2{rc_r[31]}}, rc_r, 1'b0}
                   + {{3{rr_r[31]}}, rr_r};
  assign den_s   = 35'sd2147483648 - {{2{c_r[31]}}, c_r, 1'b0};
  assign num_abs = num_s[34] ? -num_s : num_s;

  // Restoring division step on the gain
  assign div_bit = (div_it_r == 5'd31) ? m_r[1] : (div_it_r == 5'd30) ? m_r[0] : 1'b0;
  assign div_rs  = {rem_r[32:0], div_bit};
  assign div_ge  = (div_rs >= {1'b0, den_r});
  assign q_neg   = 33'd0 - {1'b0, q_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!qst.empty) begin
          state_nxt = q_item.on_ground ? BK_GROUND : BK_CORDIC;
        end
      end
      BK_GROUND: state_nxt = BK_DONE;
      BK_CORDIC: begin
        if (it_r == IT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = BK_CFIN;
        end
      end
      BK_CFIN:   state_nxt = BK_RC;
      BK_RC:     state_nxt = BK_RR;
      BK_RR:     state_nxt = BK_RRA;
      BK_RRA:    state_nxt = BK_DIVPRE;
      BK_DIVPRE: state_nxt = BK_DIVCHK;
      BK_DIVCHK: begin
        if ((den_r == '0) || ({2'b0, m_r} >= {den_r, 2'b00})) begin
          state_nxt = BK_MUL;
        end else begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_it_r == '0) begin
          state_nxt = BK_GAIN;
        end
      end
      BK_GAIN: state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_ACC;
      BK_ACC: begin
        if ((op_r == OP_LP_Z2) && (ch_r == CH_W'(CHANNELS - 1))) begin
          state_nxt = BK_DONE;
        end else begin
          state_nxt = BK_MUL;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop, multiplier operands, result load
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      BK_IDLE: pop = !qst.empty;
      BK_RC: begin
        mul_a = {4'b0, cfg.pole_radius};
        mul_b = {{2{c_r[31]}}, c_r};
      end
      BK_RR: begin
        mul_a = {4'b0, cfg.pole_radius};
        mul_b = {4'b0, cfg.pole_radius};
      end
      BK_MUL: begin
        case (op_r)
          OP_NOTCH_X1: begin
            mul_a = {c_r[31], c_r, 1'b0};
            mul_b = {{2{x1[31]}}, x1};
          end
          OP_NOTCH_GAIN: begin
            mul_a = {{2{g_r[31]}}, g_r};
            mul_b = {t_r[32], t_r};
          end
          OP_NOTCH_Y1: begin
            mul_a = {rc_r[31], rc_r, 1'b0};
            mul_b = {{2{y1[31]}}, y1};
          end
          OP_NOTCH_Y2: begin
            mul_a = {{2{rr_r[31]}}, rr_r};
            mul_b = {{2{y2[31]}}, y2};
          end
          OP_LP_Y: begin
            mul_a = {{2{cfg.lowpass_b0[31]}}, cfg.lowpass_b0};
            mul_b = {{2{y_r[31]}}, y_r};
          end
          OP_LP_L1: begin
            mul_a = {{2{cfg.lowpass_b0[31]}}, cfg.lowpass_b0};
            mul_b = {{2{l1[31]}}, l1};
          end
          OP_LP_L2: begin
            mul_a = {{2{cfg.lowpass_b0[31]}}, cfg.lowpass_b0};
            mul_b = {{2{l2[31]}}, l2};
          end
          OP_LP_Z1: begin
            mul_a = {{2{cfg.lowpass_a1[31]}}, cfg.lowpass_a1};
            mul_b = {{2{z1[31]}}, z1};
          end
          OP_LP_Z2: begin
            mul_a = {{2{cfg.lowpass_a2[31]}}, cfg.lowpass_a2};
            mul_b = {{2{z2[31]}}, z2};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      BK_DONE: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Filter histories: push on ground and after each channel in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hx1_r[i] <= '0;
        hx2_r[i] <= '0;
        hy1_r[i] <= '0;
        hy2_r[i] <= '0;
        hl1_r[i] <= '0;
        hl2_r[i] <= '0;
        hz1_r[i] <= '0;
        hz2_r[i] <= '0;
      end
    end else if (state_r == BK_GROUND) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hx1_r[i] <= cur_r.sample[i];
        hx2_r[i] <= hx1_r[i];
        hy1_r[i] <= cur_r.sample[i];
        hy2_r[i] <= hy1_r[i];
        hl1_r[i] <= cur_r.sample[i];
        hl2_r[i] <= hl1_r[i];
        hz1_r[i] <= cur_r.sample[i];
        hz2_r[i] <= hz1_r[i];
      end
    end else if ((state_r == BK_ACC) && (op_r == OP_LP_Z2)) begin
      hx1_r[ch_r] <= x_cur;
      hx2_r[ch_r] <= x1;
      hy1_r[ch_r] <= y_r;
      hy2_r[ch_r] <= y1;
      hl1_r[ch_r] <= y_r;
      hl2_r[ch_r] <= l1;
      hz1_r[ch_r] <= sat_sub;
      hz2_r[ch_r] <= z1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (load_out) begin
      out_data_r <= res_r;
      out_sat_r  <= flag_r;
    end
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          cur_r  <= q_item;
          flag_r <= 1'b0;
          flip_r <= flip_in;
          cx_r   <= CORDIC_START;
          cy_r   <= '0;
          cz_r   <= {{2{a_fold[31]}}, a_fold};
          it_r   <= '0;
        end
      end
      BK_GROUND: begin
        res_r <= cur_r.sample;
      end
      BK_CORDIC: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at34;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at34;
        end
        it_r <= it_r + 1'b1;
      end
      BK_CFIN: begin
        c_r <= flip_r ? x_neg[31:0] : x_clamped[31:0];
      end
      BK_RR: begin
        rc_r <= term[31:0];
      end
      BK_RRA: begin
        rr_r <= term[31:0];
      end
      BK_DIVPRE: begin
        neg_r <= num_s[34];
        m_r   <= num_abs[32:0];
        den_r <= den_s[32:0];
        ch_r  <= '0;
        op_r  <= OP_NOTCH_X1;
      end
      BK_DIVCHK: begin
        if (den_r == '0) begin
          g_r    <= G_MAX;
          flag_r <= 1'b1;
        end else if ({2'b0, m_r} >= {den_r, 2'b00}) begin
          g_r    <= neg_r ? G_MIN : G_MAX;
          flag_r <= 1'b1;
        end else begin
          rem_r    <= {3'b0, m_r[32:2]};
          q_r      <= '0;
          div_it_r <= 5'd31;
        end
      end
      BK_DIV: begin
        rem_r    <= div_ge ? (div_rs - {1'b0, den_r}) : div_rs;
        q_r      <= {q_r[30:0], div_ge};
        div_it_r <= div_it_r - 1'b1;
      end
      BK_GAIN: begin
        if (!neg_r) begin
          if (q_r[31]) begin
            g_r    <= G_MAX;
            flag_r <= 1'b1;
          end else begin
            g_r <= q_r;
          end
        end else if (q_r > 32'h8000_0000) begin
          g_r    <= G_MIN;
          flag_r <= 1'b1;
        end else begin
          g_r <= q_neg[31:0];
        end
      end
      BK_ACC: begin
        case (op_r)
          OP_NOTCH_X1: begin
            t_r <= sat_t;
            if (ovf_t) flag_r <= 1'b1;
            op_r <= OP_NOTCH_GAIN;
          end
          OP_NOTCH_GAIN: begin
            acc_r <= term40;
            op_r  <= OP_NOTCH_Y1;
          end
          OP_NOTCH_Y1: begin
            acc_r <= acc_r + term40;
            op_r  <= OP_NOTCH_Y2;
          end
          OP_NOTCH_Y2: begin
            y_r <= sat_sub;
            if (ovf_sub) flag_r <= 1'b1;
            op_r <= OP_LP_Y;
          end
          OP_LP_Y: begin
            acc_r <= term40;
            op_r  <= OP_LP_L1;
          end
          OP_LP_L1: begin
            acc_r <= acc_r + (term40 <<< 1);
            op_r  <= OP_LP_L2;
          end
          OP_LP_L2: begin
            acc_r <= acc_r + term40;
            op_r  <= OP_LP_Z1;
          end
          OP_LP_Z1: begin
            acc_r <= acc_r - term40;
            op_r  <= OP_LP_Z2;
          end
          OP_LP_Z2: begin
            res_r[ch_r] <= sat_sub;
            if (ovf_sub) flag_r <= 1'b1;
            ch_r <= ch_r + 1'b1;
            op_r <= OP_NOTCH_X1;
          end
          default: op_r <= OP_NOTCH_X1;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== design/tracking_notch_lowpass_filter.sv =====
// Top level of the tracking notch and Butterworth low-pass filter.
//
//   channel  direction  handshake              payload
//   in_      sink       in_valid / in_ready    in_sample_ch0..8, in_thrust, in_on_ground
//   out_     source     out_valid / out_ready  out_filtered_ch0..8, out_saturated
//   cfg_     sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item in flight goes through 30 CORDIC steps and 32 gain division steps
// (none if the divisor is zero or the gain is sure to saturate), then takes
// each channel in turn through the shared 34x34 multiplier; a ground item
// skips all of that. Reset (synchronous, rst_n low) clears all filter
// histories and loads the register defaults. Two queued items plus a front
// stage hold up to three beats while a result stalls; cfg_ready is always high.
module tracking_notch_lowpass_filter import tnlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_ch0,
  input  logic [31:0] in_sample_ch1,
  input  logic [31:0] in_sample_ch2,
  input  logic [31:0] in_sample_ch3,
  input  logic [31:0] in_sample_ch4,
  input  logic [31:0] in_sample_ch5,
  input  logic [31:0] in_sample_ch6,
  input  logic [31:0] in_sample_ch7,
  input  logic [31:0] in_sample_ch8,
  input  logic [15:0] in_thrust,
  input  logic        in_on_ground,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_filtered_ch0,
  output logic [31:0] out_filtered_ch1,
  output logic [31:0] out_filtered_ch2,
  output logic [31:0] out_filtered_ch3,
  output logic [31:0] out_filtered_ch4,
  output logic [31:0] out_filtered_ch5,
  output logic [31:0] out_filtered_ch6,
  output logic [31:0] out_filtered_ch7,
  output logic [31:0] out_filtered_ch8,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t                      cfg_r;
  logic [CHANNELS-1:0][31:0] in_sample;
  logic [CHANNELS-1:0][31:0] out_filtered;
  q_status_t                 qst;
  logic                      push, pop;
  item_t                     push_item, pop_item;

  assign cfg_ready = 1'b1;

  assign in_sample = {in_sample_ch8, in_sample_ch7, in_sample_ch6, in_sample_ch5,
                      in_sample_ch4, in_sample_ch3, in_sample_ch2, in_sample_ch1,
                      in_sample_ch0};

  assign out_filtered_ch0 = out_filtered[0];
  assign out_filtered_ch1 = out_filtered[1];
  assign out_filtered_ch2 = out_filtered[2];
  assign out_filtered_ch3 = out_filtered[3];
  assign out_filtered_ch4 = out_filtered[4];
  assign out_filtered_ch5 = out_filtered[5];
  assign out_filtered_ch6 = out_filtered[6];
  assign out_filtered_ch7 = out_filtered[7];
  assign out_filtered_ch8 = out_filtered[8];

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_slope  <= RST_PHASE_SLOPE;
      cfg_r.phase_offset <= RST_PHASE_OFFSET;
      cfg_r.pole_radius  <= RST_POLE_RADIUS;
      cfg_r.lowpass_b0   <= RST_LOWPASS_B0;
      cfg_r.lowpass_a1   <= RST_LOWPASS_A1;
      cfg_r.lowpass_a2   <= RST_LOWPASS_A2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_SLOPE:  cfg_r.phase_slope  <= cfg_data;
        CFG_PHASE_OFFSET: cfg_r.phase_offset <= cfg_data;
        CFG_POLE_RADIUS:  cfg_r.pole_radius  <= cfg_data[29:0];
        CFG_LOWPASS_B0:   cfg_r.lowpass_b0   <= cfg_data;
        CFG_LOWPASS_A1:   cfg_r.lowpass_a1   <= cfg_data;
        CFG_LOWPASS_A2:   cfg_r.lowpass_a2   <= cfg_data;
        default: ;
      endcase
    end
  end

  tnlp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .in_thrust    (in_thrust),
    .in_on_ground (in_on_ground),
    .cfg          (cfg_r),
    .qst          (qst),
    .push         (push),
    .push_item    (push_item)
  );

  tnlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qst       (qst)
  );

  tnlp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .qst           (qst),
    .q_item        (pop_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_filtered  (out_filtered),
    .out_saturated (out_saturated)
  );

endmodule

// ===== design/tnlp_checker.sv =====
// Port-level checker for the tracking notch and low-pass filter, with its bind.
`include "assert_macros.svh"

module tnlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_filtered_ch0,
  input logic        out_saturated,
  input logic        cfg_ready
);

  // Hold a stalled result beat
  `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_filtered_ch0) && $stable(out_saturated)))

  // Drop any pending result on reset
  `ASSERT_RST(a_rst_out, (!rst_n) |=> (!out_valid))

  // Take configuration writes at all times
  `ASSERT_CLK(a_cfg_ready, cfg_ready)

  // Input side only fills up after taking a beat
  `ASSERT_CLK(a_ready_fall, $fell(in_ready) |-> $past(in_valid && in_ready))

endmodule

bind tracking_notch_lowpass_filter tnlp_checker u_tnlp_checker (.*);
